@@ sv/mlcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlcd_pkg: shared definitions for the length-prefixed CRC-16 deframer
// Payload structs, phase and status codes, register indexes, reset values
// and the byte-wide CRC-16/CCITT update.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;

  localparam logic [7:0]  MAGIC_FIRST  = 8'h4D;
  localparam logic [7:0]  MAGIC_SECOND = 8'h50;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] IDLE_MAX     = 16'hFFFF;

  localparam logic [15:0] LENGTH_LIMIT_RESET  = 16'd256;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } mlcd_op_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_MAGIC1  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6
  } mlcd_phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_CRC     = 3'd3,
    ST_TIMEOUT = 3'd4
  } mlcd_status_t;

  typedef struct packed {
    mlcd_op_t   op;
    logic [7:0] data_byte;
  } mlcd_in_t;

  typedef struct packed {
    logic [7:0]   out_byte;
    logic         last;
    mlcd_status_t status;
    logic [15:0]  payload_length;
  } mlcd_out_t;

  // CRC-16/CCITT, MSB first, one byte folded in per call.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/magic_length_crc16_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_crc16_deframer: length-prefixed frame deframer with CRC-16
// Hunts for the two magic bytes, reads a 16-bit length, passes the payload
// through and checks the trailing CRC, ending each frame with a status item.
// ----------------------------------------------------------------------------
// The deframer takes one input transfer per clock cycle while in_stall is low,
// either a received byte or an idle tick, and produces at most one result
// transfer for it. The frame parser, the byte-wide CRC update and the idle
// counter all settle in the same cycle as the input transfer, so the
// sustained rate is one item per cycle while the input is not stalled. Results
// land in an output register backed by a one-entry skid register; the input
// side stalls only while the skid register holds a result, that is while the
// output register is full, downstream has stalled, and another result arrived.
// A frame is 0x4D 0x50, a big-endian length (1 to the smaller of length_limit
// and MAX_PAYLOAD), the payload, then a big-endian CRC-16/CCITT (init 0xFFFF,
// polynomial 0x1021) over the payload. Every attempt past the first magic
// byte ends with exactly one result marked last that carries the status.
module magic_length_crc16_deframer #(
  parameter int unsigned MAX_PAYLOAD = mlcd_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mlcd_pkg::mlcd_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mlcd_pkg::mlcd_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mlcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlcd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mlcd_pkg::*;

  // The byte counter only ever reaches the accepted length, which is bounded
  // by MAX_PAYLOAD.
  localparam int unsigned CntW        = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MaxPayloadW = 16'(MAX_PAYLOAD);

  // Configuration registers.
  logic [15:0] length_limit;
  logic [15:0] timeout_ticks;

  // Frame state.
  mlcd_phase_t     phase, phase_next;
  logic [15:0]     frame_length, frame_length_next;
  logic [CntW-1:0] bytes_seen, bytes_seen_next;
  logic [15:0]     running_crc, running_crc_next;
  logic [7:0]      crc_high_byte, crc_high_byte_next;
  logic [15:0]     idle_count, idle_count_next;

  // Output register and skid register.
  logic      skid_valid;
  mlcd_out_t skid_data;

  logic        accept;
  logic        res_valid;
  mlcd_out_t   res;
  logic        out_fire;
  logic [15:0] eff_limit;
  logic [15:0] len_full;
  logic [15:0] idle_inc;
  logic [CntW-1:0] cnt_inc;
  logic [15:0] crc_got;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  assign eff_limit = (length_limit > MaxPayloadW) ? MaxPayloadW : length_limit;
  assign len_full  = {frame_length[15:8], in_data.data_byte};
  assign idle_inc  = (idle_count == IDLE_MAX) ? idle_count : idle_count + 16'd1;
  assign cnt_inc   = bytes_seen + 1'b1;
  assign crc_got   = {crc_high_byte, in_data.data_byte};

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit  <= LENGTH_LIMIT_RESET;
      timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LENGTH_LIMIT:  length_limit  <= cfg_data;
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
      endcase
    end
  end

  // Parser: next frame state and the result, if any, for the input item.
  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    bytes_seen_next    = bytes_seen;
    running_crc_next   = running_crc;
    crc_high_byte_next = crc_high_byte;
    idle_count_next    = idle_count;
    res_valid          = 1'b0;
    res                = '{out_byte: 8'h00, last: 1'b0, status: ST_OK,
                           payload_length: 16'h0000};

    if (in_data.op == OP_TICK) begin
      // Ticks only count inside a frame.
      if (phase != PH_HUNT) begin
        if (idle_inc >= timeout_ticks) begin
          res_valid  = 1'b1;
          res.last   = 1'b1;
          res.status = ST_TIMEOUT;
        end else begin
          idle_count_next = idle_inc;
        end
      end
    end else begin
      idle_count_next = 16'h0000;
      unique case (phase)
        PH_HUNT: begin
          if (in_data.data_byte == MAGIC_FIRST) begin
            phase_next = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (in_data.data_byte != MAGIC_SECOND) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = ST_MAGIC;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          frame_length_next = {in_data.data_byte, 8'h00};
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = len_full;
          if (len_full == 16'h0000 || len_full > eff_limit) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            res.status = ST_LENGTH;
          end else begin
            bytes_seen_next  = '0;
            running_crc_next = CRC_INIT;
            phase_next       = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_fold(running_crc, in_data.data_byte);
          bytes_seen_next  = cnt_inc;
          if (16'(cnt_inc) >= frame_length) begin
            phase_next = PH_CRC_HI;
          end
          res_valid    = 1'b1;
          res.out_byte = in_data.data_byte;
        end
        PH_CRC_HI: begin
          crc_high_byte_next = in_data.data_byte;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (crc_got != running_crc) begin
            res.status = ST_CRC;
          end else begin
            res.status         = ST_OK;
            res.payload_length = frame_length;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end

    // Any status item, and any byte seen in an unknown phase code, returns the
    // frame state to its reset values.
    if ((res_valid && res.last) ||
        (in_data.op == OP_BYTE && phase != PH_HUNT && phase != PH_MAGIC1 &&
         phase != PH_LEN_HI && phase != PH_LEN_LO && phase != PH_PAYLOAD &&
         phase != PH_CRC_HI && phase != PH_CRC_LO)) begin
      phase_next         = PH_HUNT;
      frame_length_next  = 16'h0000;
      bytes_seen_next    = '0;
      running_crc_next   = CRC_INIT;
      crc_high_byte_next = 8'h00;
      idle_count_next    = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      frame_length  <= 16'h0000;
      bytes_seen    <= '0;
      running_crc   <= CRC_INIT;
      crc_high_byte <= 8'h00;
      idle_count    <= 16'h0000;
    end else if (accept) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      bytes_seen    <= bytes_seen_next;
      running_crc   <= running_crc_next;
      crc_high_byte <= crc_high_byte_next;
      idle_count    <= idle_count_next;
    end
  end

  // Output register with skid. While the skid register is full the input
  // side is stalled, so no new result can arrive at the same time.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      if (!out_valid || out_fire) begin
        out_data  <= res;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  // Inside the payload the length is accepted and the count is short of it.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |->
      (frame_length != 16'h0000 && frame_length <= MaxPayloadW &&
       16'(bytes_seen) < frame_length))
    else $error("payload byte count out of range");

  // A status item always sends the parser back to hunting.
  a_status_hunts: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.last) |=> (phase == PH_HUNT))
    else $error("parser did not return to hunting after a status");

  // Payload items carry no status and no length.
  a_payload_item: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |->
      (out_data.status == ST_OK && out_data.payload_length == 16'h0000))
    else $error("payload item with status or length set");

  // An ok status reports a length that was within bounds.
  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last && out_data.status == ST_OK) |->
      (out_data.payload_length != 16'h0000 && out_data.payload_length <= MaxPayloadW
       && out_data.out_byte == 8'h00))
    else $error("ok status with an impossible length");

endmodule

@@ tb/sv/magic_length_crc16_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_crc16_deframer_tb: self-checking bench for the CRC-16 deframer
// Drives received bytes and idle ticks, models the frame parser cycle by
// cycle in the bench, and checks every result transfer field by field under
// several register settings and idle patterns.
// ----------------------------------------------------------------------------
// How the bench is organized:
//   * A short table of directed items opens the run. Rows whose outcome is
//     obvious (errors, extremes, the first good frame) carry their expected
//     result inline; the rest are checked against the bench's own deframer.
//   * Random frames follow in eight settings of the two registers. Most are
//     well formed with random payloads and lengths. Some have bad magic, bad
//     lengths or corrupted CRCs. Idle ticks are sprinkled in, sometimes
//     enough to trip the timeout.
//   * Each setting uses one of four idle patterns: none, sender idling,
//     receiver stalling, or both. Halfway through every setting the sender
//     holds off until every expected result has been seen.
// Inputs are driven with nonblocking assignments at the rising edge. All
// sampling happens at the rising edge too, before those assignments land,
// so the bench sees the values that the edge itself acts on.
// ----------------------------------------------------------------------------
module magic_length_crc16_deframer_tb;

  import mlcd_pkg::*;

  localparam int unsigned PAYLOAD_MAX  = MAX_PAYLOAD_DEFAULT;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned N_SETTINGS   = 8;
  localparam int unsigned PHASE_ITEMS  = 180;
  localparam int unsigned END_GUARD    = 20000;
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  // Block ports. Every input has a known value from time zero.
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  mlcd_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  mlcd_out_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Bench copy of the registers and of the frame parser state.
  logic [15:0] cfg_len_limit;
  logic [15:0] cfg_tmo;
  mlcd_phase_t fr_phase;
  logic [15:0] fr_len;
  logic [15:0] fr_count;
  logic [15:0] fr_crc;
  logic [7:0]  fr_crc_hi;
  logic [15:0] fr_idle;

  // Results that the deframer still owes us, oldest first.
  mlcd_out_t pending_results[$];

  // Idle pattern knobs, in percent.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned payload_seen = 0;
  int unsigned status_seen [8];
  int unsigned items_counted = 0;
  int unsigned transfers_in = 0;

  // One row of the directed table. When typed is set, want and res give the
  // result read straight off the frame format; otherwise the bench model
  // decides.
  typedef struct {
    mlcd_in_t  item;
    bit        typed;
    bit        want;
    mlcd_out_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  magic_length_crc16_deframer #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench model of the deframer
  // ---------------------------------------------------------------------------

  // CRC-16/CCITT, MSB first, walking the data bits one at a time.
  function automatic logic [15:0] crc16_fold_bits(input logic [15:0] crc,
                                                  input logic [7:0]  b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // The length register is clamped by the payload buffer size.
  function automatic int unsigned eff_limit();
    return (int'(cfg_len_limit) > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(cfg_len_limit);
  endfunction

  function automatic void frame_restart();
    fr_phase  = PH_HUNT;
    fr_len    = '0;
    fr_count  = '0;
    fr_crc    = CRC_INIT;
    fr_crc_hi = '0;
    fr_idle   = '0;
  endfunction

  // Advances the bench model by one accepted item. Returns 1 when the item
  // produces a result, which is then left in res.
  function automatic bit deframe_step(input mlcd_in_t it, output mlcd_out_t res);
    bit          emitted;
    logic [15:0] got_crc;
    emitted = 1'b0;
    res     = '0;
    if (it.op == OP_TICK) begin
      // Ticks only matter once a frame has started.
      if (fr_phase != PH_HUNT) begin
        if (fr_idle != IDLE_MAX) begin
          fr_idle = fr_idle + 16'd1;
        end
        if (fr_idle >= cfg_tmo) begin
          res.last   = 1'b1;
          res.status = ST_TIMEOUT;
          emitted    = 1'b1;
          frame_restart();
        end
      end
    end else begin
      fr_idle = '0;
      case (fr_phase)
        PH_HUNT: begin
          if (it.data_byte == MAGIC_FIRST) begin
            fr_phase = PH_MAGIC1;
          end
        end
        PH_MAGIC1: begin
          if (it.data_byte != MAGIC_SECOND) begin
            res.last   = 1'b1;
            res.status = ST_MAGIC;
            emitted    = 1'b1;
            frame_restart();
          end else begin
            fr_phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          fr_len   = {it.data_byte, 8'h00};
          fr_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          fr_len = {fr_len[15:8], it.data_byte};
          if (fr_len == 16'd0 || int'(fr_len) > eff_limit()) begin
            res.last   = 1'b1;
            res.status = ST_LENGTH;
            emitted    = 1'b1;
            frame_restart();
          end else begin
            fr_count = '0;
            fr_crc   = CRC_INIT;
            fr_phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          fr_crc   = crc16_fold_bits(fr_crc, it.data_byte);
          fr_count = fr_count + 16'd1;
          if (fr_count >= fr_len) begin
            fr_phase = PH_CRC_HI;
          end
          res.out_byte = it.data_byte;
          emitted      = 1'b1;
        end
        PH_CRC_HI: begin
          fr_crc_hi = it.data_byte;
          fr_phase  = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          got_crc  = {fr_crc_hi, it.data_byte};
          res.last = 1'b1;
          if (got_crc != fr_crc) begin
            res.status = ST_CRC;
          end else begin
            res.status         = ST_OK;
            res.payload_length = fr_len;
          end
          emitted = 1'b1;
          frame_restart();
        end
        default: begin
          frame_restart();
        end
      endcase
    end
    return emitted;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t model_row(input mlcd_op_t op, input logic [7:0] b);
    stim_row_t r;
    r.item  = '{op: op, data_byte: b};
    r.typed = 1'b0;
    r.want  = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input mlcd_op_t op, input logic [7:0] b,
                                          input bit want, input logic [7:0] ob,
                                          input bit last, input mlcd_status_t st,
                                          input logic [15:0] len);
    stim_row_t r;
    r.item  = '{op: op, data_byte: b};
    r.typed = 1'b1;
    r.want  = want;
    r.res   = '{out_byte: ob, last: last, status: st, payload_length: len};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Presents one item, holds it until the transfer happens, then records what
  // the deframer owes for it. Random idle cycles go in front of the item.
  task automatic send_item(input mlcd_in_t it, input bit typed, input bit want,
                           input mlcd_out_t typed_res);
    mlcd_out_t res;
    bit        got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    // The transfer happened at this edge.
    got = deframe_step(it, res);
    if (typed) begin
      if (want) begin
        pending_results.push_back(typed_res);
      end
    end else if (got) begin
      pending_results.push_back(res);
    end
    transfers_in++;
    items_counted++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_item('{op: OP_BYTE, data_byte: b}, 1'b0, 1'b0, '0);
  endtask

  // The data field of a tick is meaningless, so it carries random bits.
  task automatic put_tick();
    send_item('{op: OP_TICK, data_byte: 8'($urandom)}, 1'b0, 1'b0, '0);
  endtask

  // Stops sending and waits until every owed result has come out, then keeps
  // the clock running so the block can finish items that produce nothing.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic load_registers(input logic [15:0] limit, input logic [15:0] tmo);
    drain_outputs();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_len_limit = limit;
    cfg_tmo       = tmo;
  endtask

  task automatic set_idle_pattern(input int unsigned pattern);
    case (pattern)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 55;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_idle_pct  = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  // Sometimes drops idle ticks into the gap between two frame bytes. Now and
  // then the count lands just under or right on the timeout.
  task automatic gap_ticks();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    n    = 0;
    if (pick < 8) begin
      n = $urandom_range(1, 3);
    end else if (pick < 9 && cfg_tmo > 1 && cfg_tmo <= 64) begin
      n = int'(cfg_tmo) - 1;
    end else if (pick < 10 && cfg_tmo <= 64) begin
      n = int'(cfg_tmo);
    end
    repeat (n) put_tick();
  endtask

  // One random frame attempt: mostly well formed, sometimes broken on
  // purpose at the magic, the length or the CRC.
  task automatic random_frame();
    int unsigned kind;
    int unsigned eff;
    int unsigned len;
    logic [15:0] flen;
    logic [15:0] crc;
    logic [7:0]  b;
    bit          bad_len;
    kind    = $urandom_range(99);
    eff     = eff_limit();
    bad_len = 1'b0;
    // Line noise while hunting; a stray first magic here is fair game.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1) == 1) begin
          put_tick();
        end else begin
          put_byte(8'($urandom));
        end
      end
    end
    put_byte(MAGIC_FIRST);
    gap_ticks();
    if (kind < 5) begin
      // Wrong second magic. A repeated first magic is included on purpose,
      // since it must not restart the frame.
      b = 8'($urandom);
      if ($urandom_range(3) == 0) begin
        b = MAGIC_FIRST;
      end else if (b == MAGIC_SECOND) begin
        b = MAGIC_SECOND + 8'd1;
      end
      put_byte(b);
    end else begin
      put_byte(MAGIC_SECOND);
      if (kind < 12) begin
        bad_len = 1'b1;
        len = ($urandom_range(1) == 1) ? 0 : $urandom_range(eff + 1, 65535);
      end else if (kind < 14 && (eff <= 16 || $urandom_range(3) == 0)) begin
        len = eff;
      end else if (kind < 28) begin
        len = $urandom_range(1, (eff < 40) ? eff : 40);
      end else begin
        len = $urandom_range(1, (eff < 6) ? eff : 6);
      end
      flen = 16'(len);
      gap_ticks();
      put_byte(flen[15:8]);
      gap_ticks();
      put_byte(flen[7:0]);
      if (!bad_len) begin
        crc = CRC_INIT;
        for (int unsigned i = 0; i < len; i++) begin
          b   = 8'($urandom);
          crc = crc16_fold_bits(crc, b);
          gap_ticks();
          put_byte(b);
        end
        // Roughly one frame in ten carries a single flipped CRC bit.
        if (kind >= 28 && kind < 38) begin
          crc = crc ^ (16'd1 << $urandom_range(15));
        end
        gap_ticks();
        put_byte(crc[15:8]);
        gap_ticks();
        put_byte(crc[7:0]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic note_failure(input string what, input mlcd_out_t w,
                              input mlcd_out_t g);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected byte %02h last %0d status %0d len %0d,",
               $realtime, what, w.out_byte, w.last, w.status, w.payload_length);
      $display("    got byte %02h last %0d status %0d len %0d",
               g.out_byte, g.last, g.status, g.payload_length);
    end
  endtask

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    mlcd_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure("result with nothing owed", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_byte != want.out_byte || out_data.last != want.last ||
            out_data.status != want.status ||
            out_data.payload_length != want.payload_length) begin
          note_failure("result mismatch", want, out_data);
        end
      end
      results_checked++;
      if (out_data.last) begin
        status_seen[out_data.status]++;
      end else begin
        payload_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int unsigned set_limit [N_SETTINGS];
    int unsigned set_tmo   [N_SETTINGS];
    int unsigned start;
    int unsigned guard;
    stim_row_t   r;

    cfg_len_limit = LENGTH_LIMIT_RESET;
    cfg_tmo       = TIMEOUT_TICKS_RESET;
    frame_restart();
    foreach (status_seen[i]) status_seen[i] = 0;

    // Register settings per phase: reset values, the two extremes, a limit
    // above the payload buffer, tight timeouts and two random picks.
    set_limit = '{256, 1, 65535, 300, 0, 3, 0, 256};
    set_tmo   = '{1000, 1, 65535, 5, 0, 2, 0, 12};
    set_limit[4] = $urandom_range(1, 65535);
    set_tmo[4]   = $urandom_range(1, 40);
    set_limit[6] = $urandom_range(1, 512);
    set_tmo[6]   = $urandom_range(1, 65535);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The length limit stays at its reset value; the timeout
    // is shortened so that an idle abort fits in a few rows.
    load_registers(LENGTH_LIMIT_RESET, 16'd2);

    // A tick while hunting does nothing.
    directed_rows.push_back(typed_row(OP_TICK, 8'hFF, 1'b0, 8'h00, 1'b0, ST_OK, 16'd0));
    // First magic twice: the second one is a bad second magic.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(typed_row(OP_BYTE, MAGIC_FIRST, 1'b1, 8'h00, 1'b1,
                                      ST_MAGIC, 16'd0));
    // Zero length is rejected right after the low length byte.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_SECOND));
    directed_rows.push_back(model_row(OP_BYTE, 8'h00));
    directed_rows.push_back(typed_row(OP_BYTE, 8'h00, 1'b1, 8'h00, 1'b1,
                                      ST_LENGTH, 16'd0));
    // One more than the limit is rejected too.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_SECOND));
    directed_rows.push_back(model_row(OP_BYTE, 8'h01));
    directed_rows.push_back(typed_row(OP_BYTE, 8'h01, 1'b1, 8'h00, 1'b1,
                                      ST_LENGTH, 16'd0));
    // Good one-byte frame with payload 0x00, whose CRC is 0xE1F0.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_SECOND));
    directed_rows.push_back(model_row(OP_BYTE, 8'h00));
    directed_rows.push_back(model_row(OP_BYTE, 8'h01));
    directed_rows.push_back(typed_row(OP_BYTE, 8'h00, 1'b1, 8'h00, 1'b0,
                                      ST_OK, 16'd0));
    directed_rows.push_back(model_row(OP_BYTE, 8'hE1));
    directed_rows.push_back(typed_row(OP_BYTE, 8'hF0, 1'b1, 8'h00, 1'b1,
                                      ST_OK, 16'd1));
    // Payload 0xFF has CRC 0xFF00; sending 0xFF01 must be a CRC mismatch.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_SECOND));
    directed_rows.push_back(model_row(OP_BYTE, 8'h00));
    directed_rows.push_back(model_row(OP_BYTE, 8'h01));
    directed_rows.push_back(typed_row(OP_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b0,
                                      ST_OK, 16'd0));
    directed_rows.push_back(model_row(OP_BYTE, 8'hFF));
    directed_rows.push_back(typed_row(OP_BYTE, 8'h01, 1'b1, 8'h00, 1'b1,
                                      ST_CRC, 16'd0));
    // Two ticks after the first magic hit the shortened timeout.
    directed_rows.push_back(model_row(OP_BYTE, MAGIC_FIRST));
    directed_rows.push_back(model_row(OP_TICK, 8'h00));
    directed_rows.push_back(typed_row(OP_TICK, 8'h00, 1'b1, 8'h00, 1'b1,
                                      ST_TIMEOUT, 16'd0));

    set_idle_pattern(0);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_item(r.item, r.typed, r.want, r.res);
    end

    // Random part, one register setting and one idle pattern per phase.
    for (int unsigned p = 0; p < N_SETTINGS; p++) begin
      load_registers(16'(set_limit[p]), 16'(set_tmo[p]));
      set_idle_pattern(p % 4);
      start = items_counted;
      while (items_counted - start < PHASE_ITEMS / 2) begin
        random_frame();
      end
      // Hold the sender off until the deframer has caught up completely.
      drain_outputs();
      while (items_counted - start < PHASE_ITEMS) begin
        random_frame();
      end
    end

    // Wind down: let every owed result out, then watch a little longer for
    // anything extra.
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < END_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0d expected results never came out", pending_results.size());
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d input transfers over %0d register settings and four idle patterns;",
             transfers_in, N_SETTINGS + 1);
    $display("checked %0d results (%0d payload bytes).", results_checked, payload_seen);
    $display("Frame ends seen: %0d ok, %0d bad magic, %0d bad length,",
             status_seen[ST_OK], status_seen[ST_MAGIC], status_seen[ST_LENGTH]);
    $display("%0d crc mismatch, %0d timeout.",
             status_seen[ST_CRC], status_seen[ST_TIMEOUT]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
